/* rtl/gbt_pkg.sv */
package gbt_pkg;

	// node ids and counts
	localparam int NODE_W = 5;
	localparam int NODES  = 1 << NODE_W;
	localparam int CNT_W  = NODE_W + 1;

	// stream word widths
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int TDATA_IN_W  = 16;
	localparam int TDATA_OUT_W = 16;

	typedef logic [NODE_W-1:0]   node_t;
	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	// operation codes
	localparam op_t OP_ADD = 2'd0;
	localparam op_t OP_BFS = 2'd1;
	localparam op_t OP_DFS = 2'd2;
	localparam op_t OP_NOP = 2'd3;

	// result status codes
	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_SELF = 2'd1;
	localparam status_t ST_FULL = 2'd2;
	localparam status_t ST_BAD  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic set_bad;
		logic len_src;
		logic len_dst;
		logic wr_fwd;
		logic wr_rev;
		logic emit_result;
		logic init_trav;
		logic pop;
		logic read_len;
		logic emit_visit;
		logic scan;
		logic finish;
	} gbt_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic dfs;
		logic trav_bad;
		logic wl_empty;
		logic out_free;
		logic scan_done;
		logic descend;
	} gbt_sts_t;

endpackage

/* rtl/gbt_ctrl.sv */
module gbt_ctrl import gbt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  gbt_sts_t sts,
	output gbt_cmd_t cmd
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_DECODE     = 4'd1;
	localparam logic [3:0] S_E_SRC      = 4'd2;
	localparam logic [3:0] S_E_DST      = 4'd3;
	localparam logic [3:0] S_E_WR1      = 4'd4;
	localparam logic [3:0] S_E_WR2      = 4'd5;
	localparam logic [3:0] S_RESULT     = 4'd6;
	localparam logic [3:0] S_T_INIT     = 4'd7;
	localparam logic [3:0] S_POP        = 4'd8;
	localparam logic [3:0] S_LEN_VISIT  = 4'd9;
	localparam logic [3:0] S_LEN_RESUME = 4'd10;
	localparam logic [3:0] S_EMIT       = 4'd11;
	localparam logic [3:0] S_SCAN       = 4'd12;
	localparam logic [3:0] S_FINISH     = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.op)
					OP_ADD: state_d = S_E_SRC;
					OP_BFS, OP_DFS: begin
						if (sts.trav_bad) begin
							cmd.set_bad = 1'b1;
							state_d     = S_RESULT;
						end else begin
							state_d = S_T_INIT;
						end
					end
					OP_NOP: state_d = S_IDLE;
				endcase
			end
			S_E_SRC: begin
				cmd.len_src = 1'b1;
				state_d     = S_E_DST;
			end
			S_E_DST: begin
				cmd.len_dst = 1'b1;
				state_d     = S_E_WR1;
			end
			S_E_WR1: begin
				cmd.wr_fwd = 1'b1;
				state_d    = S_E_WR2;
			end
			S_E_WR2: begin
				cmd.wr_rev = 1'b1;
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.emit_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_T_INIT: begin
				cmd.init_trav = 1'b1;
				state_d       = sts.dfs ? S_LEN_VISIT : S_POP;
			end
			S_POP: begin
				if (sts.wl_empty) begin
					state_d = S_FINISH;
				end else begin
					cmd.pop = 1'b1;
					state_d = sts.dfs ? S_LEN_RESUME : S_LEN_VISIT;
				end
			end
			S_LEN_VISIT: begin
				cmd.read_len = 1'b1;
				state_d      = S_EMIT;
			end
			S_LEN_RESUME: begin
				cmd.read_len = 1'b1;
				state_d      = S_SCAN;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_visit = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.descend) begin
					state_d = S_LEN_VISIT;
				end else if (sts.scan_done) begin
					state_d = S_POP;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/gbt_datapath.sv */
module gbt_datapath import gbt_pkg::*; #(
	parameter int MAX_DEGREE = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gbt_cmd_t         cmd,
	output gbt_sts_t         sts,
	input  op_t              op,
	input  node_t            src_node,
	input  node_t            dst_node,
	input  logic             directed,
	input  node_t            start_node,
	input  logic             cfg_valid,
	input  logic [CNT_W-1:0] cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output node_t            out_node,
	output node_t            out_depth,
	output logic             out_empty,
	output status_t          out_status,
	output logic             out_last
);

	localparam int IDX_W     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int LEN_W     = $clog2(MAX_DEGREE + 1);
	localparam int AW        = NODE_W + IDX_W;
	localparam int ADJ_DEPTH = NODES << IDX_W;
	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_DEGREE);
	localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

	// item and register
	logic [CNT_W-1:0] nc_q;
	logic [CNT_W-1:0] nc;
	op_t              op_q;
	node_t            src_q;
	node_t            dst_q;
	logic             dir_q;
	node_t            start_q;
	status_t          status_q;
	status_t          edge_stat;
	logic             dfs;

	// adjacency lists
	node_t            adj_mem [ADJ_DEPTH];
	node_t            adj_rdata_s1;
	logic             adj_we;
	logic [AW-1:0]    adj_waddr;
	node_t            adj_wdata;
	logic [AW-1:0]    adj_raddr;
	logic [LEN_W-1:0] list_len_q [NODES];
	logic [LEN_W-1:0] len_rd;
	node_t            len_ra;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_b_q;
	logic             fwd_ok;
	logic             rev_ok;

	// traversal
	logic [NODES-1:0] seen_q;
	node_t            wl_node_q  [NODES];
	logic [LEN_W-1:0] wl_idx_q   [NODES];
	node_t            wl_depth_q [NODES];
	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] tail_q;
	logic [CNT_W-1:0] wl_ra;
	logic             wl_we;
	node_t            wl_wa;
	node_t            wl_wnode;
	logic [LEN_W-1:0] wl_widx;
	node_t            wl_wdepth;
	node_t            cur_node_q;
	node_t            cur_depth_q;
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] idx_s1;
	logic             rd_v_s1;
	node_t            nb;
	logic             found;
	logic             descend;
	logic             issue;

	// pending visit and output word
	logic             pend_valid_q;
	node_t            pend_node_q;
	node_t            pend_depth_q;
	logic             pend_empty_q;
	logic             out_valid_q;
	node_t            out_node_q;
	node_t            out_depth_q;
	logic             out_empty_q;
	status_t          out_status_q;
	logic             out_last_q;
	logic             out_free;

	always_comb begin
		priority if (nc_q == '0) begin
			nc = CNT_W'(1);
		end else if (nc_q > CNT_W'(NODES)) begin
			nc = CNT_W'(NODES);
		end else begin
			nc = nc_q;
		end
	end

	assign dfs = (op_q == OP_DFS);

	always_comb begin
		priority if ({1'b0, src_q} >= nc || {1'b0, dst_q} >= nc) begin
			edge_stat = ST_BAD;
		end else if (src_q == dst_q) begin
			edge_stat = ST_SELF;
		end else if (len_q == LEN_FULL || (!dir_q && len_b_q == LEN_FULL)) begin
			edge_stat = ST_FULL;
		end else begin
			edge_stat = ST_OK;
		end
	end

	assign fwd_ok = cmd.wr_fwd && (edge_stat == ST_OK);
	assign rev_ok = cmd.wr_rev && (status_q == ST_OK) && !dir_q;

	// single read port on the list lengths
	assign len_ra = cmd.len_dst ? dst_q : (cmd.len_src ? src_q : cur_node_q);
	assign len_rd = list_len_q[len_ra];

	// adjacency write and scan read
	always_comb begin
		adj_we    = fwd_ok || rev_ok;
		adj_waddr = {src_q, len_q[IDX_W-1:0]};
		adj_wdata = dst_q;
		if (rev_ok) begin
			adj_waddr = {dst_q, len_b_q[IDX_W-1:0]};
			adj_wdata = src_q;
		end
	end

	assign adj_raddr = {cur_node_q, idx_q[IDX_W-1:0]};
	assign nb        = adj_rdata_s1;
	assign found     = cmd.scan && rd_v_s1 && ({1'b0, nb} < nc) && !seen_q[nb];
	assign descend   = found && dfs;
	assign issue     = cmd.scan && (idx_q < len_q) && !descend;

	// work list: queue from head to tail, or stack of tail entries
	assign wl_ra = dfs ? (tail_q - CNT_W'(1)) : head_q;

	always_comb begin
		wl_we     = 1'b0;
		wl_wa     = tail_q[NODE_W-1:0];
		wl_wnode  = nb;
		wl_widx   = '0;
		wl_wdepth = cur_depth_q + NODE_W'(1);
		if (cmd.init_trav && !dfs) begin
			wl_we     = 1'b1;
			wl_wa     = '0;
			wl_wnode  = start_q;
			wl_wdepth = '0;
		end else if (found) begin
			wl_we = 1'b1;
			if (dfs) begin
				// parent resumes after the neighbour just taken
				wl_wnode  = cur_node_q;
				wl_widx   = idx_s1 + LEN_ONE;
				wl_wdepth = cur_depth_q;
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_waddr] <= adj_wdata;
		end
		adj_rdata_s1 <= adj_mem[adj_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q         <= CNT_W'(NODES);
			seen_q       <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			rd_v_s1      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NODES; i++) begin
				list_len_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				nc_q <= cfg_data;
			end
			if (fwd_ok) begin
				list_len_q[src_q] <= len_q + LEN_ONE;
			end else if (rev_ok) begin
				list_len_q[dst_q] <= len_b_q + LEN_ONE;
			end
			rd_v_s1 <= issue;
			if (cmd.init_trav) begin
				// only the start node is marked
				seen_q <= NODES'(1) << start_q;
				head_q <= '0;
				tail_q <= dfs ? CNT_W'(0) : CNT_W'(1);
			end else if (cmd.pop) begin
				if (dfs) begin
					tail_q <= tail_q - CNT_W'(1);
				end else begin
					head_q <= head_q + CNT_W'(1);
				end
			end else if (found) begin
				seen_q[nb] <= 1'b1;
				tail_q     <= tail_q + CNT_W'(1);
			end
			if (cmd.emit_visit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.emit_result || cmd.finish || (cmd.emit_visit && pend_valid_q)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			src_q   <= src_node;
			dst_q   <= dst_node;
			dir_q   <= directed;
			start_q <= start_node;
		end
		if (cmd.set_bad) begin
			status_q <= ST_BAD;
		end else if (cmd.wr_fwd) begin
			status_q <= edge_stat;
		end
		if (cmd.len_src || cmd.read_len) begin
			len_q <= len_rd;
		end
		if (cmd.len_dst) begin
			len_b_q <= len_rd;
		end
		if (wl_we) begin
			wl_node_q[wl_wa]  <= wl_wnode;
			wl_idx_q[wl_wa]   <= wl_widx;
			wl_depth_q[wl_wa] <= wl_wdepth;
		end
		if (cmd.init_trav) begin
			cur_node_q  <= start_q;
			cur_depth_q <= '0;
			idx_q       <= '0;
		end else if (cmd.pop) begin
			cur_node_q  <= wl_node_q[wl_ra[NODE_W-1:0]];
			cur_depth_q <= wl_depth_q[wl_ra[NODE_W-1:0]];
			idx_q       <= wl_idx_q[wl_ra[NODE_W-1:0]];
		end else if (descend) begin
			cur_node_q  <= nb;
			cur_depth_q <= cur_depth_q + NODE_W'(1);
			idx_q       <= '0;
		end else if (issue) begin
			idx_q <= idx_q + LEN_ONE;
		end
		idx_s1 <= idx_q;
		if (cmd.emit_visit) begin
			pend_node_q  <= cur_node_q;
			pend_depth_q <= cur_depth_q;
			pend_empty_q <= (len_q == '0);
		end
		if (cmd.emit_result) begin
			out_node_q   <= '0;
			out_depth_q  <= '0;
			out_empty_q  <= 1'b0;
			out_status_q <= status_q;
			out_last_q   <= 1'b1;
		end else if (cmd.finish || (cmd.emit_visit && pend_valid_q)) begin
			out_node_q   <= pend_node_q;
			out_depth_q  <= pend_depth_q;
			out_empty_q  <= pend_empty_q;
			out_status_q <= ST_OK;
			out_last_q   <= cmd.finish;
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.dfs       = dfs;
		sts.trav_bad  = ({1'b0, start_q} >= nc);
		sts.wl_empty  = dfs ? (tail_q == '0) : (head_q == tail_q);
		sts.out_free  = out_free;
		sts.scan_done = (idx_q == len_q) && !rd_v_s1;
		sts.descend   = descend;
	end

	assign out_valid  = out_valid_q;
	assign out_node   = out_node_q;
	assign out_depth  = out_depth_q;
	assign out_empty  = out_empty_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

endmodule

/* rtl/graph_bfs_dfs_traversal.sv */
// graph search engine: keeps one adjacency list per node (up to MAX_DEGREE
// neighbours, insertion order) and answers three kinds of input word, chosen
// by s_tuser: add edge, breadth-first search, depth-first search (preorder).
// an add-edge word reads both list lengths, writes the edge and, if it is
// accepted and undirected, its reverse, then waits for the output register
// and returns one status word. a search returns one word per reached node
// with its discovery depth and an empty-list flag, m_tlast on the final one;
// a bad start node returns a single status word. search time is set by the
// adjacency memory read port, one list slot per cycle while a node's list
// is scanned. one word is worked on at a time; s_tready comes back once the
// last result has entered the output register, even if that word is still
// waiting to be taken. node_count may be written at any time through cfg_*
// and is clamped to 1..32; list entries at or above it are skipped during a
// search
module graph_bfs_dfs_traversal import gbt_pkg::*; #(
	parameter int MAX_DEGREE = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// node_count register
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CNT_W-1:0]       cfg_data,
	// input words
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,  // src_node, dst_node, directed, start_node
	input  logic [OP_W-1:0]        s_tuser,  // op
	// result words
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,  // visit_node, visit_depth, no_successors, zero pad
	output logic [STATUS_W-1:0]    m_tuser,  // status
	output logic                   m_tlast
);

	localparam int PAD_W = TDATA_OUT_W - 2 * NODE_W - 1;

	gbt_cmd_t cmd;
	gbt_sts_t sts;
	node_t    out_node;
	node_t    out_depth;
	logic     out_empty;

	// register writes never stall
	assign cfg_ready = 1'b1;

	gbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// input word unpacked from the lowest bit up
	gbt_datapath #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (s_tuser),
		.src_node   (s_tdata[NODE_W-1:0]),
		.dst_node   (s_tdata[2*NODE_W-1:NODE_W]),
		.directed   (s_tdata[2*NODE_W]),
		.start_node (s_tdata[3*NODE_W:2*NODE_W+1]),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_node   (out_node),
		.out_depth  (out_depth),
		.out_empty  (out_empty),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

	assign m_tdata = {{PAD_W{1'b0}}, out_empty, out_depth, out_node};

endmodule

/* rtl/gbt_checker.sv */
module gbt_checker import gbt_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [TDATA_OUT_W-1:0] m_tdata,
	input logic [STATUS_W-1:0]    m_tuser,
	input logic                   m_tlast
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result word changed while stalled");

	// one word in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while previous word still in work");

	// a status other than ok is a lone word with empty data
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata == '0)
		else $error("status word not last or carries data");

	// register writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

endmodule

bind graph_bfs_dfs_traversal gbt_checker u_checker (.*);
